### rtl/core/rtu_pkg.sv
// Package for the rigid transform unit: item types, fixed-point constants,
// operation codes and the shared round-and-saturate function.
// No dependencies.
`timescale 1ns / 1ps

package rtu_pkg;

	// Fixed-point format of every stored entry and every result
	localparam int VALUE_WIDTH   = 32;
	localparam int FRACTION_BITS = 16;

	// Operand, product and accumulator widths follow from the value format
	localparam int OPND_W = VALUE_WIDTH + 1;
	localparam int PROD_W = 2 * OPND_W;
	localparam int ACC_W  = 2 * VALUE_WIDTH + 4;

	localparam int ENTRY_CNT = 12;
	localparam int PROD_CNT  = 9;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic signed [OPND_W-1:0]      opnd_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [ACC_W-1:0]       acc_t;

	typedef value_t [ENTRY_CNT-1:0] entry_set_t;
	typedef prod_t  [PROD_CNT-1:0]  prod_set_t;
	typedef value_t [2:0]           vec3_t;

	typedef logic [1:0] op_t;

	localparam op_t OP_SET       = 2'd0;
	localparam op_t OP_POINT     = 2'd1;
	localparam op_t OP_DIRECTION = 2'd2;
	localparam op_t OP_INVERSE   = 2'd3;

	localparam value_t VAL_ONE  = value_t'(1) << FRACTION_BITS;
	localparam value_t VAL_ZERO = '0;
	localparam value_t VAL_MAX  = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam value_t VAL_MIN  = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam acc_t   ACC_ONE  = acc_t'(1) << (2 * FRACTION_BITS);
	localparam acc_t   ACC_HALF = acc_t'(1) << (FRACTION_BITS - 1);

	// Identity rotation with zero translation; entry 0 sits in the lowest slot.
	localparam entry_set_t ENTRY_RESET = {
		VAL_ZERO, VAL_ONE,  VAL_ZERO, VAL_ZERO,
		VAL_ZERO, VAL_ZERO, VAL_ONE,  VAL_ZERO,
		VAL_ZERO, VAL_ZERO, VAL_ZERO, VAL_ONE
	};

	typedef struct packed {
		op_t    operation;
		value_t quat_r;
		value_t quat_i;
		value_t quat_j;
		value_t quat_k;
		value_t vec_x;
		value_t vec_y;
		value_t vec_z;
	} item_t;

	typedef struct packed {
		value_t out_x;
		value_t out_y;
		value_t out_z;
	} result_t;

	// Sign-extend a stored value to multiplier operand width.
	function automatic opnd_t to_opnd(input value_t v);
		return opnd_t'(v);
	endfunction

	// Sign-extend a product to accumulator width.
	function automatic acc_t to_acc(input prod_t p);
		return acc_t'(p);
	endfunction

	// Round from double to single fraction precision, ties towards plus
	// infinity, then saturate to the signed value range.
	function automatic value_t round_sat(input acc_t a);
		acc_t sum;
		acc_t shr;
		logic all_one;
		logic all_zero;
		sum      = a + ACC_HALF;
		shr      = sum >>> FRACTION_BITS;
		all_one  = &shr[ACC_W-1:VALUE_WIDTH-1];
		all_zero = ~|shr[ACC_W-1:VALUE_WIDTH-1];
		if (all_one || all_zero) begin
			return shr[VALUE_WIDTH-1:0];
		end else if (shr[ACC_W-1]) begin
			return VAL_MIN;
		end else begin
			return VAL_MAX;
		end
	endfunction

endpackage

### rtl/core/rtu_entry_store.sv
// Twelve transform entries, row-major 3x4, reset to identity with zero
// translation. Depends on rtu_pkg.
`timescale 1ns / 1ps

module rtu_entry_store
	import rtu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  entry_set_t wr_entries,
	output entry_set_t entries
);

	entry_set_t entries_q;

	// A set item replaces the whole matrix in a single write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRY_RESET;
		end else if (wr_en) begin
			entries_q <= wr_entries;
		end
	end

	assign entries = entries_q;

endmodule

### rtl/core/rtu_product_array.sv
// Nine signed multipliers shared by the set, point, direction and inverse
// operations, with their operand selection. Depends on rtu_pkg.
`timescale 1ns / 1ps

module rtu_product_array
	import rtu_pkg::*;
(
	input  item_t      item,
	input  entry_set_t entries,
	output prod_set_t  products
);

	vec3_t vec;
	opnd_t [PROD_CNT-1:0] opnd_a;
	opnd_t [PROD_CNT-1:0] opnd_b;

	assign vec[0] = item.vec_x;
	assign vec[1] = item.vec_y;
	assign vec[2] = item.vec_z;

	// Operand selection. For a set item the multipliers form the nine
	// distinct quaternion products; otherwise product 3*row+col is one term
	// of the row's dot product.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (item.operation == OP_INVERSE) begin
					opnd_a[3*r+c] = to_opnd(entries[4*c+r]);
					opnd_b[3*r+c] = to_opnd(vec[c]) - to_opnd(entries[4*c+3]);
				end else begin
					opnd_a[3*r+c] = to_opnd(entries[4*r+c]);
					opnd_b[3*r+c] = to_opnd(vec[c]);
				end
			end
		end
		if (item.operation == OP_SET) begin
			opnd_a[0] = to_opnd(item.quat_i); opnd_b[0] = to_opnd(item.quat_i);
			opnd_a[1] = to_opnd(item.quat_j); opnd_b[1] = to_opnd(item.quat_j);
			opnd_a[2] = to_opnd(item.quat_k); opnd_b[2] = to_opnd(item.quat_k);
			opnd_a[3] = to_opnd(item.quat_i); opnd_b[3] = to_opnd(item.quat_j);
			opnd_a[4] = to_opnd(item.quat_i); opnd_b[4] = to_opnd(item.quat_k);
			opnd_a[5] = to_opnd(item.quat_j); opnd_b[5] = to_opnd(item.quat_k);
			opnd_a[6] = to_opnd(item.quat_i); opnd_b[6] = to_opnd(item.quat_r);
			opnd_a[7] = to_opnd(item.quat_j); opnd_b[7] = to_opnd(item.quat_r);
			opnd_a[8] = to_opnd(item.quat_k); opnd_b[8] = to_opnd(item.quat_r);
		end
	end

	// The multipliers themselves
	for (genvar k = 0; k < PROD_CNT; k++) begin : g_mul
		assign products[k] = prod_t'(opnd_a[k]) * prod_t'(opnd_b[k]);
	end

endmodule

### rtl/core/rtu_combine.sv
// Sums the nine products into either the new rotation entries or the three
// transformed coordinates, with rounding and saturation. Depends on rtu_pkg.
`timescale 1ns / 1ps

module rtu_combine
	import rtu_pkg::*;
(
	input  item_t      item,
	input  entry_set_t entries,
	input  prod_set_t  products,
	output entry_set_t new_entries,
	output result_t    result
);

	acc_t [PROD_CNT-1:0] pk;
	acc_t [PROD_CNT-1:0] pk2;
	acc_t [2:0]          row_acc;
	vec3_t               row_val;

	// Widen every product; the doubled form serves the quaternion terms.
	always_comb begin
		for (int k = 0; k < PROD_CNT; k++) begin
			pk[k]  = to_acc(products[k]);
			pk2[k] = pk[k] + pk[k];
		end
	end

	// New matrix for a set item. Products: 0 ii, 1 jj, 2 kk, 3 ij, 4 ik,
	// 5 jk, 6 ir, 7 jr, 8 kr. The position is stored unchanged.
	always_comb begin
		new_entries[0]  = round_sat(ACC_ONE - pk2[1] - pk2[2]);
		new_entries[1]  = round_sat(pk2[3] + pk2[8]);
		new_entries[2]  = round_sat(pk2[4] - pk2[7]);
		new_entries[3]  = item.vec_x;
		new_entries[4]  = round_sat(pk2[3] - pk2[8]);
		new_entries[5]  = round_sat(ACC_ONE - pk2[0] - pk2[2]);
		new_entries[6]  = round_sat(pk2[5] + pk2[6]);
		new_entries[7]  = item.vec_y;
		new_entries[8]  = round_sat(pk2[4] + pk2[7]);
		new_entries[9]  = round_sat(pk2[5] - pk2[6]);
		new_entries[10] = round_sat(ACC_ONE - pk2[0] - pk2[1]);
		new_entries[11] = item.vec_z;
	end

	// Row sums; a point item also adds the translation, aligned to the
	// double-precision fraction.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			row_acc[r] = pk[3*r] + pk[3*r+1] + pk[3*r+2];
			if (item.operation == OP_POINT) begin
				row_acc[r] = row_acc[r] + (acc_t'(entries[4*r+3]) <<< FRACTION_BITS);
			end
			row_val[r] = round_sat(row_acc[r]);
		end
	end

	assign result.out_x = row_val[0];
	assign result.out_y = row_val[1];
	assign result.out_z = row_val[2];

endmodule

### rtl/core/rigid_transform_unit.sv
// Rigid transform unit: top level with input register, result register and
// handshake control. Depends on rtu_pkg, rtu_entry_store, rtu_product_array
// and rtu_combine.
`timescale 1ns / 1ps

// Applies a stored 3x4 rigid transform to Q16.16 vectors. A set item loads
// the rotation from a quaternion (used as given, not normalised) and the
// translation from the vector fields, and returns nothing; point, direction
// and inverse-point items each return one saturated vector. Each item is held
// in the input register and its result is then held in the result register;
// the unit takes one item per cycle for as long as results are taken; the
// rate is set by the single bank of nine 33-bit multipliers, which every
// operation uses once. A point that follows a set directly already sees the
// new transform. After reset the transform is the identity with zero
// translation.
module rigid_transform_unit
	import rtu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	item_t      item_s1;
	logic       valid_s1;
	logic       is_set_s1;
	logic       done_s1;
	result_t    result_q;
	logic       result_valid_q;
	entry_set_t entries;
	entry_set_t new_entries;
	prod_set_t  products;
	result_t    result_d;

	// The item in the input register leaves when it is a set item or when
	// the result register is free or being emptied.
	assign is_set_s1  = (item_s1.operation == OP_SET);
	assign done_s1    = valid_s1 && (is_set_s1 || !result_valid_q || result_ready);
	assign item_ready = !valid_s1 || done_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// Transform storage, multipliers and summation
	rtu_entry_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (done_s1 && is_set_s1),
		.wr_entries (new_entries),
		.entries    (entries)
	);

	rtu_product_array u_products (
		.item     (item_s1),
		.entries  (entries),
		.products (products)
	);

	rtu_combine u_combine (
		.item        (item_s1),
		.entries     (entries),
		.products    (products),
		.new_entries (new_entries),
		.result      (result_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (done_s1 && !is_set_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1 && !is_set_s1) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
